FILE: rtl/potts_metropolis_site_update_defines.svh
// ----------------------------------------------------------------------------
// potts metropolis site update: assertion macros
// shared macros for the concurrent checks on the block ports
// ----------------------------------------------------------------------------
`ifndef POTTS_METROPOLIS_SITE_UPDATE_DEFINES_SVH
`define POTTS_METROPOLIS_SITE_UPDATE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PMSU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PMSU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pmsu_pkg.sv
// ----------------------------------------------------------------------------
// pmsu_pkg
// types, constants and helpers shared by the potts site update block
// ----------------------------------------------------------------------------
`default_nettype none

package pmsu_pkg;

	// lattice geometry: side is a power of two so wrap is plain coordinate overflow
	localparam int SIDE    = 64;
	localparam int COORD_W = $clog2(SIDE);
	localparam int DEPTH   = SIDE * SIDE;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SPIN_W  = 2;
	localparam int FRAC_W  = 32;
	localparam int CHG_W   = 4;
	localparam int NUM_THR = 4;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THR1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THR2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THR4 = 3'd3;

	// command codes, the unused code behaves as a read
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	typedef logic [SPIN_W-1:0] spin_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [NUM_THR-1:0][FRAC_W-1:0] thr_arr_t;
	typedef spin_t [3:0] nbr_arr_t;

	// outcome of one metropolis evaluation
	typedef struct packed {
		spin_t                   prop;
		logic                    acc;
		logic signed [CHG_W-1:0] change;
	} eval_res_t;

	// row-major site address
	function automatic addr_t site_addr(input coord_t row, input coord_t col);
		site_addr = {row, col};
	endfunction

	// spin value reduced into the three legal states
	function automatic spin_t spin_mod3(input spin_t s);
		spin_mod3 = (s == 2'd3) ? 2'd0 : s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pmsu_ram.sv
// ----------------------------------------------------------------------------
// pmsu_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pmsu_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pmsu_eval.sv
// ----------------------------------------------------------------------------
// pmsu_eval
// neighbor match counting and metropolis acceptance decision
// ----------------------------------------------------------------------------
`default_nettype none

module pmsu_eval
	import pmsu_pkg::*;
(
	input  wire spin_t              cur,
	input  wire nbr_arr_t           nbr,
	input  wire logic               pick,
	input  wire logic [FRAC_W-1:0]  draw,
	input  wire thr_arr_t           thr,
	output eval_res_t               res
);

	logic [2:0]              prop_sum;
	spin_t                   prop;
	logic [2:0]              m_cur;
	logic [2:0]              m_prop;
	logic signed [CHG_W-1:0] change;
	logic [1:0]              thr_sel;

	// proposed spin: current plus one or two, modulo three
	always_comb begin
		prop_sum = {1'b0, cur} + 3'd1 + {2'b00, pick};
		prop     = (prop_sum >= 3'd3) ? 2'(prop_sum - 3'd3) : prop_sum[1:0];
	end

	// count matching neighbors
	always_comb begin
		m_cur  = '0;
		m_prop = '0;
		for (int k = 0; k < 4; k++) begin
			m_cur  = m_cur + {2'b00, (nbr[k] == cur)};
			m_prop = m_prop + {2'b00, (nbr[k] == prop)};
		end
	end

	// a fall of d selects threshold d, index is ~change for negative change
	always_comb begin
		change  = $signed({1'b0, m_prop}) - $signed({1'b0, m_cur});
		thr_sel = ~change[1:0];
		res.prop   = prop;
		res.change = change;
		res.acc    = !change[CHG_W-1] || (draw < thr[thr_sel]);
	end

endmodule

`default_nettype wire

FILE: rtl/potts_metropolis_site_update.sv
// Write and read go from idle straight to the final step; an update first steps
// through the up, down, left and right reads. One command at a time: the input
// stalls until idle; the lattice memory has a single read port (center plus four neighbors).
// A result waiting on a stalled output holds the sequencer in its final state.
// Reset clears the sequencer, the output valid and the four thresholds to zero;
// lattice contents stay undefined until written.
// ----------------------------------------------------------------------------
// potts_metropolis_site_update
// three-state potts lattice with write, read and metropolis update commands
// ----------------------------------------------------------------------------
`default_nettype none

module potts_metropolis_site_update
	import pmsu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           command,
	input  wire logic [COORD_W-1:0]   site_row,
	input  wire logic [COORD_W-1:0]   site_col,
	input  wire logic [SPIN_W-1:0]    write_spin,
	input  wire logic                 proposal_pick,
	input  wire logic [FRAC_W-1:0]    uniform_draw,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [SPIN_W-1:0]         site_spin,
	output logic                      accepted,
	output logic signed [CHG_W-1:0]   match_change,
	// configuration channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [FRAC_W-1:0]    cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_UP   = 6'b000010,
		ST_DN   = 6'b000100,
		ST_LF   = 6'b001000,
		ST_RT   = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	coord_t             row_q, col_q;
	spin_t              wspin_q;
	logic               pick_q;
	logic [FRAC_W-1:0]  draw_q;
	spin_t              cur_q;
	spin_t              nb_up_q, nb_dn_q, nb_lf_q;
	thr_arr_t           thr_q;
	logic               out_valid_q;
	spin_t              site_spin_q;
	logic               accepted_q;
	logic signed [CHG_W-1:0] change_q;

	logic               in_fire;
	logic               fin_fire;
	logic               ram_re, ram_we;
	addr_t              ram_raddr;
	spin_t              ram_wdata;
	spin_t              ram_rdata;
	nbr_arr_t           nbr;
	eval_res_t          ev;
	spin_t              res_spin;
	logic               res_acc;
	logic signed [CHG_W-1:0] res_change;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign fin_fire  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THR1: thr_q[0] <= cfg_data;
				REG_THR2: thr_q[1] <= cfg_data;
				REG_THR3: thr_q[2] <= cfg_data;
				REG_THR4: thr_q[3] <= cfg_data;
				default:  ;
			endcase
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (cmd_t'(command) == CMD_UPDATE) ? ST_UP : ST_FIN;
				end
			end
			ST_UP:   state_d = ST_DN;
			ST_DN:   state_d = ST_LF;
			ST_LF:   state_d = ST_RT;
			ST_RT:   state_d = ST_FIN;
			ST_FIN: begin
				if (fin_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the command transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q   <= cmd_t'(command);
			row_q   <= site_row;
			col_q   <= site_col;
			wspin_q <= spin_mod3(write_spin);
			pick_q  <= proposal_pick;
			draw_q  <= uniform_draw;
		end
	end

	// lattice read address per step: center, then up, down, left, right
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = site_addr(site_row, site_col);
		case (state_q)
			ST_IDLE: begin
				ram_re    = in_fire;
				ram_raddr = site_addr(site_row, site_col);
			end
			ST_UP: begin
				ram_re    = 1'b1;
				ram_raddr = site_addr(row_q - COORD_W'(1), col_q);
			end
			ST_DN: begin
				ram_re    = 1'b1;
				ram_raddr = site_addr(row_q + COORD_W'(1), col_q);
			end
			ST_LF: begin
				ram_re    = 1'b1;
				ram_raddr = site_addr(row_q, col_q - COORD_W'(1));
			end
			ST_RT: begin
				ram_re    = 1'b1;
				ram_raddr = site_addr(row_q, col_q + COORD_W'(1));
			end
			default: ram_re = 1'b0;
		endcase
	end

	// collect center and neighbor spins as the reads return
	always_ff @(posedge clk) begin
		case (state_q)
			ST_UP: cur_q   <= ram_rdata;
			ST_DN: nb_up_q <= ram_rdata;
			ST_LF: nb_dn_q <= ram_rdata;
			ST_RT: nb_lf_q <= ram_rdata;
			default: ;
		endcase
	end

	// right neighbor is still on the read data in the final step
	assign nbr = {ram_rdata, nb_lf_q, nb_dn_q, nb_up_q};

	pmsu_eval u_eval (
		.cur  (cur_q),
		.nbr  (nbr),
		.pick (pick_q),
		.draw (draw_q),
		.thr  (thr_q),
		.res  (ev)
	);

	// result and write-back selection per command
	always_comb begin
		res_spin   = ram_rdata;
		res_acc    = 1'b0;
		res_change = '0;
		ram_we     = 1'b0;
		ram_wdata  = wspin_q;
		case (cmd_q)
			CMD_WRITE: begin
				res_spin  = wspin_q;
				ram_we    = fin_fire;
				ram_wdata = wspin_q;
			end
			CMD_UPDATE: begin
				res_spin   = ev.acc ? ev.prop : cur_q;
				res_acc    = ev.acc;
				res_change = ev.change;
				ram_we     = fin_fire && ev.acc;
				ram_wdata  = ev.prop;
			end
			default: res_spin = ram_rdata;
		endcase
	end

	pmsu_ram #(
		.WIDTH (SPIN_W),
		.DEPTH (DEPTH)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (site_addr(row_q, col_q)),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			site_spin_q <= res_spin;
			accepted_q  <= res_acc;
			change_q    <= res_change;
		end
	end

	assign out_valid    = out_valid_q;
	assign site_spin    = site_spin_q;
	assign accepted     = accepted_q;
	assign match_change = change_q;

endmodule

`default_nettype wire

FILE: rtl/pmsu_checker.sv
// ----------------------------------------------------------------------------
// pmsu_checker
// port-level checks on the potts site update block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "potts_metropolis_site_update_defines.svh"

module pmsu_checker
	import pmsu_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire logic [1:0]           command,
	input wire logic [COORD_W-1:0]   site_row,
	input wire logic [COORD_W-1:0]   site_col,
	input wire logic [SPIN_W-1:0]    write_spin,
	input wire logic                 proposal_pick,
	input wire logic [FRAC_W-1:0]    uniform_draw,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [SPIN_W-1:0]    site_spin,
	input wire logic                 accepted,
	input wire logic signed [CHG_W-1:0] match_change,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [FRAC_W-1:0]    cfg_data
);

	// one command at a time: an accepted transaction blocks the next cycle
	`PMSU_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall,
		"command accepted while previous one still in flight")

	// a non-negative nonzero match change is always accepted
	`PMSU_ASSERT_IMP(a_rise_accepted, clk, arst_n,
		out_valid && !match_change[CHG_W-1] && (match_change != '0), accepted,
		"non-falling update move was rejected")

	// a fall is at most four
	`PMSU_ASSERT_IMP(a_fall_range, clk, arst_n, out_valid && match_change[CHG_W-1],
		match_change[CHG_W-2], "match change below minus four")

	// reported spin is always a legal state
	`PMSU_ASSERT_IMP(a_spin_legal, clk, arst_n, out_valid, site_spin != 2'd3,
		"result spin outside the three states")

	// stalled result holds
	`PMSU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(site_spin) && $stable(accepted) && $stable(match_change),
		"stalled result changed")

endmodule

bind potts_metropolis_site_update pmsu_checker u_pmsu_checker (.*);

`default_nettype wire

FILE: tb/potts_metropolis_site_update_test.sv
// ----------------------------------------------------------------------------
// potts_metropolis_site_update_test
// self-checking bench for the three-state potts site update block: a queue of
// write, read and metropolis update commands feeds a handshaked driver, a
// lattice predictor works out each result at acceptance, and a monitor checks
// every result field against the oldest prediction. threshold registers are
// reprogrammed between traffic phases while the block is idle.
// ----------------------------------------------------------------------------
module potts_metropolis_site_update_test
	import pmsu_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 100;

	// one command transaction as driven on the input ports
	typedef struct packed {
		cmd_t              cmd;
		coord_t            row;
		coord_t            col;
		spin_t             wspin;
		logic              pick;
		logic [FRAC_W-1:0] draw;
	} site_cmd_t;

	// one result transaction
	typedef struct packed {
		spin_t                   spin;
		logic                    acc;
		logic signed [CHG_W-1:0] change;
	} site_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	site_cmd_t drive_cmd = '0;
	logic [1:0] command;
	logic [COORD_W-1:0] site_row;
	logic [COORD_W-1:0] site_col;
	logic [SPIN_W-1:0] write_spin;
	logic proposal_pick;
	logic [FRAC_W-1:0] uniform_draw;

	logic out_valid;
	logic out_stall = 1'b1;
	logic [SPIN_W-1:0] site_spin;
	logic accepted;
	logic signed [CHG_W-1:0] match_change;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FRAC_W-1:0] cfg_data = '0;

	// handshakes seen at the last rising edge
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic cfg_fire = 1'b0;

	// predictor state: lattice copy and acceptance thresholds
	spin_t lattice [SIDE][SIDE];
	logic [FRAC_W-1:0] thr_reg [NUM_THR] = '{default: '0};

	// sites that already hold a spin, tracked in generation order
	bit site_loaded [SIDE][SIDE];

	site_cmd_t site_cmd_queue [$];
	site_result_t predicted_results [$];
	site_result_t want;

	int send_wait = 2;
	int recv_wait = 3;
	bit no_idle = 1'b0;
	spin_t dominant_spin = '0;
	int error_count = 0;
	int idle_cycles = 0;

	assign command       = drive_cmd.cmd;
	assign site_row      = drive_cmd.row;
	assign site_col      = drive_cmd.col;
	assign write_spin    = drive_cmd.wspin;
	assign proposal_pick = drive_cmd.pick;
	assign uniform_draw  = drive_cmd.draw;

	potts_metropolis_site_update dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.site_row     (site_row),
		.site_col     (site_col),
		.write_spin   (write_spin),
		.proposal_pick(proposal_pick),
		.uniform_draw (uniform_draw),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.site_spin    (site_spin),
		.accepted     (accepted),
		.match_change (match_change),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// apply one command to the lattice copy and return its result
	function automatic site_result_t apply_site_command(input site_cmd_t c);
		site_result_t r;
		spin_t cur;
		spin_t prop;
		spin_t around [4];
		int same_cur;
		int same_prop;
		int fall;
		r = '0;
		case (c.cmd)
			CMD_WRITE: begin
				lattice[c.row][c.col] = spin_t'(c.wspin % 3);
			end
			CMD_UPDATE: begin
				cur = lattice[c.row][c.col];
				prop = spin_t'((cur + 32'd1 + c.pick) % 3);
				// wrapped neighbors: up, down, left, right
				around[0] = lattice[coord_t'(c.row - 1)][c.col];
				around[1] = lattice[coord_t'(c.row + 1)][c.col];
				around[2] = lattice[c.row][coord_t'(c.col - 1)];
				around[3] = lattice[c.row][coord_t'(c.col + 1)];
				same_cur = 0;
				same_prop = 0;
				foreach (around[k]) begin
					same_cur += (around[k] == cur);
					same_prop += (around[k] == prop);
				end
				r.change = CHG_W'(same_prop - same_cur);
				fall = same_cur - same_prop;
				// a fall in match count needs the draw under its threshold
				if (fall <= 0) begin
					r.acc = 1'b1;
				end else begin
					r.acc = (c.draw < thr_reg[fall - 1]);
				end
				if (r.acc) begin
					lattice[c.row][c.col] = prop;
				end
			end
			default: begin
			end
		endcase
		r.spin = lattice[c.row][c.col];
		return r;
	endfunction

	function automatic void queue_command(input cmd_t cmd, input coord_t row, input coord_t col,
			input spin_t wspin, input logic pick, input logic [FRAC_W-1:0] draw);
		site_cmd_t c;
		c = '{cmd, row, col, wspin, pick, draw};
		if (cmd == CMD_WRITE) begin
			site_loaded[row][col] = 1'b1;
		end
		site_cmd_queue.push_back(c);
	endfunction

	// random command, mostly inside an 8x8 window that straddles the wrap
	function automatic void queue_random_command();
		cmd_t cmd;
		coord_t row;
		coord_t col;
		spin_t wspin;
		logic [FRAC_W-1:0] draw;
		int roll;
		roll = $urandom_range(0, 99);
		cmd = (roll < 35) ? CMD_WRITE : (roll < 82) ? CMD_UPDATE :
			(roll < 95) ? CMD_READ : CMD_SPARE;
		if ($urandom_range(0, 99) < 85) begin
			row = coord_t'(60 + $urandom_range(0, 7));
			col = coord_t'(60 + $urandom_range(0, 7));
		end else begin
			row = coord_t'($urandom);
			col = coord_t'($urandom);
		end
		// a dominant spin makes large match changes common
		wspin = $urandom_range(0, 1) ? dominant_spin : spin_t'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0: draw = '0;
			1: draw = '1;
			2: draw = thr_reg[$urandom_range(0, 3)] + FRAC_W'($urandom_range(0, 2))
				- FRAC_W'(1);
			default: draw = $urandom;
		endcase
		// never touch a site that holds no spin yet
		if (cmd == CMD_UPDATE && !(site_loaded[row][col]
				&& site_loaded[coord_t'(row - 1)][col] && site_loaded[coord_t'(row + 1)][col]
				&& site_loaded[row][coord_t'(col - 1)] && site_loaded[row][coord_t'(col + 1)])) begin
			cmd = CMD_WRITE;
		end
		if ((cmd == CMD_READ || cmd == CMD_SPARE) && !site_loaded[row][col]) begin
			cmd = CMD_WRITE;
		end
		queue_command(cmd, row, col, wspin, 1'($urandom_range(0, 1)), draw);
	endfunction

	// program all four thresholds, block must be idle
	task automatic set_thresholds(input logic [FRAC_W-1:0] t1, input logic [FRAC_W-1:0] t2,
			input logic [FRAC_W-1:0] t3, input logic [FRAC_W-1:0] t4);
		logic [FRAC_W-1:0] vals [NUM_THR];
		logic [CFG_IDX_W-1:0] idx [NUM_THR];
		vals = '{t1, t2, t3, t4};
		idx = '{REG_THR1, REG_THR2, REG_THR3, REG_THR4};
		for (int i = 0; i < NUM_THR; i++) begin
			@(negedge clk);
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(negedge clk); while (!cfg_fire);
			cfg_valid <= 1'b0;
		end
	endtask

	// hold off until every queued command is answered, then let the block settle
	task automatic wait_for_drain();
		do @(negedge clk);
		while (site_cmd_queue.size() != 0 || in_valid || predicted_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// command driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (in_fire) begin
					send_wait = no_idle ? 0 : $urandom_range(0, 5);
				end
				if (send_wait == 0 && site_cmd_queue.size() != 0) begin
					drive_cmd <= site_cmd_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					if (send_wait > 0) begin
						send_wait--;
					end
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall pattern
	always @(negedge clk) begin
		if (out_fire) begin
			recv_wait = no_idle ? 0 : $urandom_range(0, 5);
		end
		if (recv_wait > 0) begin
			out_stall <= 1'b1;
			recv_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// predictor and result checker
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		out_fire <= arst_n && out_valid && !out_stall;
		cfg_fire <= arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_THR) begin
				thr_reg[cfg_index] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				predicted_results.push_back(apply_site_command(drive_cmd));
			end
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					error_count++;
					$display("%0t: result transaction with none pending: spin %0d acc %0d change %0d",
						$time, site_spin, accepted, match_change);
				end else begin
					want = predicted_results.pop_front();
					if (site_spin !== want.spin) begin
						error_count++;
						$display("%0t: site_spin expected %0d actual %0d",
							$time, want.spin, site_spin);
					end
					if (accepted !== want.acc) begin
						error_count++;
						$display("%0t: accepted expected %0d actual %0d",
							$time, want.acc, accepted);
					end
					if (match_change !== want.change) begin
						error_count++;
						$display("%0t: match_change expected %0d actual %0d",
							$time, want.change, match_change);
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: wrap corner, full rise and fall of matches, odd spin and command codes
		set_thresholds(32'h8000_0000, 32'h4000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_command(CMD_WRITE, 6'd0, 6'd0, 2'd0, 1'b0, '0);
		queue_command(CMD_WRITE, 6'd63, 6'd0, 2'd0, 1'b0, '0);
		queue_command(CMD_WRITE, 6'd1, 6'd0, 2'd0, 1'b0, '0);
		queue_command(CMD_WRITE, 6'd0, 6'd63, 2'd0, 1'b0, '0);
		queue_command(CMD_WRITE, 6'd0, 6'd1, 2'd0, 1'b0, '0);
		// fall by four, draw at the top of range is never below the threshold
		queue_command(CMD_UPDATE, 6'd0, 6'd0, 2'd0, 1'b0, 32'hFFFF_FFFF);
		queue_command(CMD_UPDATE, 6'd0, 6'd0, 2'd0, 1'b0, 32'hFFFF_FFFE);
		// rise by four
		queue_command(CMD_UPDATE, 6'd0, 6'd0, 2'd0, 1'b1, 32'h1234_5678);
		// spin three stores as zero, at the far corner
		queue_command(CMD_WRITE, 6'd63, 6'd63, 2'd3, 1'b0, '0);
		queue_command(CMD_READ, 6'd63, 6'd63, 2'd0, 1'b0, '0);
		queue_command(CMD_WRITE, 6'd0, 6'd1, 2'd1, 1'b0, '0);
		queue_command(CMD_WRITE, 6'd1, 6'd0, 2'd2, 1'b0, '0);
		// fall by one with a zero draw
		queue_command(CMD_UPDATE, 6'd0, 6'd0, 2'd0, 1'b0, 32'h0000_0000);
		// no change in matches
		queue_command(CMD_UPDATE, 6'd0, 6'd0, 2'd0, 1'b0, 32'hFFFF_FFFF);
		// spare command code reads back
		queue_command(CMD_SPARE, 6'd0, 6'd0, 2'd3, 1'b1, 32'hFFFF_FFFF);
		queue_command(CMD_READ, 6'd63, 6'd0, 2'd0, 1'b0, '0);
		wait_for_drain();

		// random phases under different acceptance settings
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_thresholds('0, '0, '0, '0);
				1: set_thresholds('1, '1, '1, '1);
				2: set_thresholds(32'h9B45_97E4, 32'h5E2D_58D8, 32'h391F_3B0F, 32'h22A5_5548);
				default: set_thresholds($urandom, $urandom, $urandom, $urandom);
			endcase
			no_idle = (phase == 1);
			dominant_spin = spin_t'(phase % 3);
			repeat (PHASE_ITEMS) queue_random_command();
			wait_for_drain();
		end

		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
